FILE: design/scq_pkg.sv
// shared types, constants and key tables for the scancode queue
`timescale 1ns / 1ps

package scq_pkg;

   // default number of queue slots (one slot always stays empty)
   localparam int QUEUE_DEPTH_DEF = 64;

   // field widths
   localparam int SCAN_W = 8;
   localparam int CHAR_W = 7;
   localparam int CODE_W = 7;
   localparam int FILL_W = 6;

   // item kinds
   localparam logic KIND_SCAN = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // scancode set 1 values
   localparam logic [SCAN_W-1:0] SC_EXT_PREFIX = 8'hE0;
   localparam logic [CODE_W-1:0] SC_LSHIFT     = 7'h2A;
   localparam logic [CODE_W-1:0] SC_RSHIFT     = 7'h36;
   localparam logic [CODE_W-1:0] SC_ALT        = 7'h38;
   localparam logic [CODE_W-1:0] SC_CTRL       = 7'h1D;
   localparam int                SC_RELEASE_BIT = 7;

   // per-item status carried from the controller down the pipe
   typedef struct packed {
      logic              rd_hit;
      logic              dropped;
      logic              shift;
      logic              ctrl;
      logic              alt;
      logic [FILL_W-1:0] fill;
   } scq_status_type;

   // unshifted key table, codes without an entry give zero
   function automatic logic [CHAR_W-1:0] plain_char(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] c;
      unique case (code)
         7'd2:  c = 7'h31;
         7'd3:  c = 7'h32;
         7'd4:  c = 7'h33;
         7'd5:  c = 7'h34;
         7'd6:  c = 7'h35;
         7'd7:  c = 7'h36;
         7'd8:  c = 7'h37;
         7'd9:  c = 7'h38;
         7'd10: c = 7'h39;
         7'd11: c = 7'h30;
         7'd12: c = 7'h2D;
         7'd13: c = 7'h3D;
         7'd14: c = 7'h08;
         7'd15: c = 7'h09;
         7'd16: c = 7'h71;
         7'd17: c = 7'h77;
         7'd18: c = 7'h65;
         7'd19: c = 7'h72;
         7'd20: c = 7'h74;
         7'd21: c = 7'h79;
         7'd22: c = 7'h75;
         7'd23: c = 7'h69;
         7'd24: c = 7'h6F;
         7'd25: c = 7'h70;
         7'd26: c = 7'h5B;
         7'd27: c = 7'h5D;
         7'd28: c = 7'h0A;
         7'd30: c = 7'h61;
         7'd31: c = 7'h73;
         7'd32: c = 7'h64;
         7'd33: c = 7'h66;
         7'd34: c = 7'h67;
         7'd35: c = 7'h68;
         7'd36: c = 7'h6A;
         7'd37: c = 7'h6B;
         7'd38: c = 7'h6C;
         7'd39: c = 7'h3B;
         7'd40: c = 7'h27;
         7'd41: c = 7'h60;
         7'd43: c = 7'h5C;
         7'd44: c = 7'h7A;
         7'd45: c = 7'h78;
         7'd46: c = 7'h63;
         7'd47: c = 7'h76;
         7'd48: c = 7'h62;
         7'd49: c = 7'h6E;
         7'd50: c = 7'h6D;
         7'd51: c = 7'h2C;
         7'd52: c = 7'h2E;
         7'd53: c = 7'h2F;
         7'd55: c = 7'h2A;
         7'd57: c = 7'h20;
         7'd74: c = 7'h2D;
         7'd78: c = 7'h2B;
         default: c = '0;
      endcase
      return c;
   endfunction

   // shifted key table
   function automatic logic [CHAR_W-1:0] shift_char(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] c;
      unique case (code)
         7'd2:  c = 7'h21;
         7'd3:  c = 7'h40;
         7'd4:  c = 7'h23;
         7'd5:  c = 7'h24;
         7'd6:  c = 7'h25;
         7'd7:  c = 7'h5E;
         7'd8:  c = 7'h26;
         7'd9:  c = 7'h2A;
         7'd10: c = 7'h28;
         7'd11: c = 7'h29;
         7'd12: c = 7'h5F;
         7'd13: c = 7'h2B;
         7'd14: c = 7'h08;
         7'd15: c = 7'h09;
         7'd16: c = 7'h51;
         7'd17: c = 7'h57;
         7'd18: c = 7'h45;
         7'd19: c = 7'h52;
         7'd20: c = 7'h54;
         7'd21: c = 7'h59;
         7'd22: c = 7'h55;
         7'd23: c = 7'h49;
         7'd24: c = 7'h4F;
         7'd25: c = 7'h50;
         7'd26: c = 7'h7B;
         7'd27: c = 7'h7D;
         7'd28: c = 7'h0A;
         7'd30: c = 7'h41;
         7'd31: c = 7'h53;
         7'd32: c = 7'h44;
         7'd33: c = 7'h46;
         7'd34: c = 7'h47;
         7'd35: c = 7'h48;
         7'd36: c = 7'h4A;
         7'd37: c = 7'h4B;
         7'd38: c = 7'h4C;
         7'd39: c = 7'h3A;
         7'd40: c = 7'h22;
         7'd41: c = 7'h7E;
         7'd43: c = 7'h7C;
         7'd44: c = 7'h5A;
         7'd45: c = 7'h58;
         7'd46: c = 7'h43;
         7'd47: c = 7'h56;
         7'd48: c = 7'h42;
         7'd49: c = 7'h4E;
         7'd50: c = 7'h4D;
         7'd51: c = 7'h3C;
         7'd52: c = 7'h3E;
         7'd53: c = 7'h3F;
         7'd55: c = 7'h2A;
         7'd57: c = 7'h20;
         7'd74: c = 7'h2D;
         7'd78: c = 7'h2B;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

FILE: design/scq_ram.sv
// character store: one write port, one registered read port
`timescale 1ns / 1ps

module scq_ram #(
   parameter int DEPTH  = scq_pkg::QUEUE_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [scq_pkg::CHAR_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [scq_pkg::CHAR_W-1:0]  rd_data
);

   logic [scq_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [scq_pkg::CHAR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/scq_ctrl.sv
// key decoder, modifier flags and queue pointers
`timescale 1ns / 1ps

module scq_ctrl #(
   parameter int DEPTH = scq_pkg::QUEUE_DEPTH_DEF,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_accept,
   input  logic                          kind,
   input  logic [scq_pkg::SCAN_W-1:0]    scan_byte,
   output logic                          wr_en,
   output logic [PTR_W-1:0]              wr_addr,
   output logic [scq_pkg::CHAR_W-1:0]    wr_data,
   output logic                          rd_en,
   output logic [PTR_W-1:0]              rd_addr,
   output scq_pkg::scq_status_type       status
);

   localparam int CALC_W = (PTR_W + 1 > scq_pkg::FILL_W) ? PTR_W + 1 : scq_pkg::FILL_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   logic             ext_ff, ext_in;
   logic             shift_ff, shift_in;
   logic             ctrl_ff, ctrl_in;
   logic             alt_ff, alt_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;

   logic                       release_key;
   logic [scq_pkg::CODE_W-1:0] code;
   logic [scq_pkg::CHAR_W-1:0] key_char;
   logic [PTR_W-1:0]           wp_next;
   logic [PTR_W-1:0]           rp_next;
   logic                       queue_empty;
   logic                       dropped;
   logic                       push;
   logic                       pop;
   logic [CALC_W-1:0]          wp_ext;
   logic [CALC_W-1:0]          rp_ext;
   logic [CALC_W-1:0]          fill_calc;

   // byte split and table lookup
   assign release_key = scan_byte[scq_pkg::SC_RELEASE_BIT];
   assign code        = scan_byte[scq_pkg::CODE_W-1:0];
   assign key_char    = shift_ff ? scq_pkg::shift_char(code) : scq_pkg::plain_char(code);

   // ring wrap
   assign wp_next     = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
   assign rp_next     = (rp_ff == LAST_SLOT) ? '0 : rp_ff + 1'b1;
   assign queue_empty = (rp_ff == wp_ff);

   // item decode
   always_comb begin
      ext_in   = ext_ff;
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      alt_in   = alt_ff;
      push     = 1'b0;
      pop      = 1'b0;
      dropped  = 1'b0;
      if (item_accept) begin
         if (kind == scq_pkg::KIND_READ) begin
            pop = !queue_empty;
         end else if (scan_byte == scq_pkg::SC_EXT_PREFIX) begin
            ext_in = 1'b1;
         end else begin
            ext_in = 1'b0;
            // extended codes match nothing
            if (!ext_ff) begin
               priority if (code == scq_pkg::SC_LSHIFT || code == scq_pkg::SC_RSHIFT) begin
                  shift_in = !release_key;
               end else if (code == scq_pkg::SC_ALT) begin
                  alt_in = !release_key;
               end else if (code == scq_pkg::SC_CTRL) begin
                  ctrl_in = !release_key;
               end else if (!release_key && key_char != '0) begin
                  if (wp_next == rp_ff) begin
                     dropped = 1'b1;
                  end else begin
                     push = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign wp_in = push ? wp_next : wp_ff;
   assign rp_in = pop ? rp_next : rp_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff   <= 1'b0;
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         alt_ff   <= 1'b0;
         wp_ff    <= '0;
         rp_ff    <= '0;
      end else begin
         ext_ff   <= ext_in;
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         alt_ff   <= alt_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
      end
   end

   // fill level after this item
   assign wp_ext    = CALC_W'(wp_in);
   assign rp_ext    = CALC_W'(rp_in);
   assign fill_calc = (wp_in >= rp_in) ? (wp_ext - rp_ext)
                                       : (wp_ext + CALC_W'(DEPTH) - rp_ext);

   // memory ports and status
   assign wr_en   = push;
   assign wr_addr = wp_ff;
   assign wr_data = key_char;
   assign rd_en   = pop;
   assign rd_addr = rp_ff;

   assign status.rd_hit  = pop;
   assign status.dropped = dropped;
   assign status.shift   = shift_in;
   assign status.ctrl    = ctrl_in;
   assign status.alt     = alt_in;
   assign status.fill    = fill_calc[scq_pkg::FILL_W-1:0];

endmodule

FILE: design/scancode_to_ascii_queue_top.sv
// top level: scancode decoder with character queue and output stage
`timescale 1ns / 1ps

// Usage
// The req channel carries one item per handshake: req_kind low sends a set 1
// scancode byte on req_scan_byte, req_kind high asks for one character. Every
// item gives exactly one rsp item with the popped character (or read_valid low
// when the queue was empty), a dropped flag for a full queue, the shift, ctrl
// and alt flags and the fill count after that item.
// The decode and the pointer update happen in the accept cycle; the item then
// moves to the middle stage while the character memory registers its read
// data, and then to the output register, which drives rsp_valid. One item is
// accepted every cycle while req_stall is low; an item uses at most one of the
// separate read and write ports of the character memory.
// Synchronous reset clears the flags, the pending prefix and both pointers;
// the queue is empty after reset and no clearing pass is needed.
// While rsp_stall is high the output register holds its item; one more item
// may sit in the middle stage, and req_stall rises once both are full.
// The queue keeps QUEUE_DEPTH-1 characters; fill count reports its low six bits.

module scancode_to_ascii_queue_top #(
   parameter int QUEUE_DEPTH = scq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [scq_pkg::SCAN_W-1:0]   req_scan_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [scq_pkg::CHAR_W-1:0]   rsp_read_char,
   output logic                         rsp_read_valid,
   output logic                         rsp_char_dropped,
   output logic                         rsp_shift_held,
   output logic                         rsp_ctrl_held,
   output logic                         rsp_alt_held,
   output logic [scq_pkg::FILL_W-1:0]   rsp_fill_count
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic                        accept;
   logic                        wr_en;
   logic [PTR_W-1:0]            wr_addr;
   logic [scq_pkg::CHAR_W-1:0]  wr_data;
   logic                        rd_en;
   logic [PTR_W-1:0]            rd_addr;
   logic [scq_pkg::CHAR_W-1:0]  rd_data;
   scq_pkg::scq_status_type     status;

   logic                        s1_valid_ff, s1_valid_in;
   scq_pkg::scq_status_type     s1_status_ff;
   logic                        s1_advance;

   logic                        out_valid_ff, out_valid_in;
   scq_pkg::scq_status_type     out_status_ff;
   logic [scq_pkg::CHAR_W-1:0]  out_char_ff;

   // handshake
   assign s1_advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && out_valid_ff && rsp_stall;
   assign accept     = req_valid && !req_stall;

   scq_ctrl #(
      .DEPTH (QUEUE_DEPTH),
      .PTR_W (PTR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .kind        (req_kind),
      .scan_byte   (req_scan_byte),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .status      (status)
   );

   scq_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // middle stage waits for the memory read data
   assign s1_valid_in = accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status;
      end
   end

   // output register
   assign out_valid_in = s1_advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_status_ff <= s1_status_ff;
         out_char_ff   <= s1_status_ff.rd_hit ? rd_data : '0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_char    = out_char_ff;
   assign rsp_read_valid   = out_status_ff.rd_hit;
   assign rsp_char_dropped = out_status_ff.dropped;
   assign rsp_shift_held   = out_status_ff.shift;
   assign rsp_ctrl_held    = out_status_ff.ctrl;
   assign rsp_alt_held     = out_status_ff.alt;
   assign rsp_fill_count   = out_status_ff.fill;

`ifndef SYNTHESIS
   // an item never both pushes and pops the queue
   a_no_push_and_pop: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("queue push and pop in the same cycle");

   // stalling the input only when both stages hold an item
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff))
      else $error("input stalled with a free stage");

   // a popped character is never zero and a read never drops
   a_read_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_valid) |-> (rsp_read_char != '0 && !rsp_char_dropped))
      else $error("read returned a zero character or a drop");

   // a read on the memory is followed by its item in the middle stage
   a_read_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (s1_valid_ff && s1_status_ff.rd_hit))
      else $error("memory read without its item in the middle stage");
`endif

endmodule
